/* hdl/sobel_gradient_magnitude_defines.svh */
// assertion macros for the sobel gradient magnitude block
`ifndef SOBEL_GRADIENT_MAGNITUDE_DEFINES_SVH
`define SOBEL_GRADIENT_MAGNITUDE_DEFINES_SVH
`ifndef SYNTHESIS
`define SGM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgm same-cycle check failed");
`define SGM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgm next-cycle check failed");
`else
`define SGM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SGM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/sgm_pkg.sv */
// types and constants shared by the sobel gradient magnitude block
`timescale 1ns / 1ps
package sgm_pkg;

   localparam logic       REG_IMAGE_WIDTH  = 1'b0;
   localparam logic       REG_IMAGE_HEIGHT = 1'b1;
   localparam logic [9:0]  WIDTH_RESET     = 10'd384;
   localparam logic [11:0] HEIGHT_RESET    = 12'd384;

   typedef struct packed {
      logic [7:0] pixel;
      logic       flush;
   } req_type;

   typedef struct packed {
      logic [7:0] magnitude;
      logic       row_end;
      logic       frame_end;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic square;
      logic sum;
      logic root_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic has_result;
      logic root_done;
      logic out_free;
   } sts_type;

endpackage

/* hdl/sgm_control.sv */
// sequencing state machine for the sobel gradient magnitude block
`timescale 1ns / 1ps
module sgm_control
   import sgm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = sts.has_result ? ST_SQUARE : ST_IDLE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (sts.root_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

endmodule

/* hdl/sgm_datapath.sv */
// line buffers, window, gradient, square root and result register
`timescale 1ns / 1ps
`include "sobel_gradient_magnitude_defines.svh"
module sgm_datapath
   import sgm_pkg::*;
#(
   parameter int MAX_WIDTH = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  req_type     req_data,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = CW + 1;

   logic [9:0]    width_ff;
   logic [11:0]   height_ff;
   logic [WW-1:0] w_eff;
   logic [11:0]   h_eff;

   logic [CW-1:0] col_ff, col_in, ic, cc, w_last;
   logic [12:0]   row_ff, row_in, h_ext;
   logic [WW-1:0] ic_next;
   logic [11:0]   cr;
   logic          case_a, case_b, is_re, is_bot, last;

   logic [7:0]    older_mem [MAX_WIDTH];
   logic [7:0]    newer_mem [MAX_WIDTH];
   logic [7:0]    rd_older_ff, rd_newer_ff, pix_ff;
   logic [CW-1:0] addr_ff;
   logic          has_ff, ml_ff, mr_ff, mt_ff, mb_ff, row_end_ff, frame_end_ff;

   logic [7:0]    win_ff [3][3];
   logic [7:0]    nw [3][3];
   logic signed [10:0] ps [3][3];
   logic signed [10:0] gx, gy, gx_ff, gy_ff;
   logic signed [21:0] gx_sq, gy_sq;
   logic [19:0]   gx2_ff, gy2_ff;
   logic [20:0]   sum;
   logic [15:0]   rad_ff, t_sq;
   logic [7:0]    root_ff, t;
   logic [2:0]    bit_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   // effective geometry
   always_comb begin
      if (width_ff == 10'd0) begin
         w_eff = WW'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      h_eff = (height_ff == 12'd0) ? 12'd1 : height_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         if (csr_index == REG_IMAGE_WIDTH) begin
            width_ff <= csr_wdata[9:0];
         end else begin
            height_ff <= csr_wdata;
         end
      end
   end

   // position and result classification
   always_comb begin
      ic      = (WW'(col_ff) >= w_eff) ? '0 : col_ff;
      ic_next = WW'(ic) + WW'(1);
      h_ext   = {1'b0, h_eff};
      w_last  = CW'(w_eff - WW'(1));
      case_a  = (ic == '0) && (row_ff >= 13'd2) && (row_ff <= h_ext + 13'd1);
      case_b  = (ic != '0) && (row_ff >= 13'd1) && (row_ff <= h_ext);
      cr      = case_a ? 12'(row_ff - 13'd2) : 12'(row_ff - 13'd1);
      cc      = case_a ? w_last : ic - CW'(1);
      is_re   = (cc == w_last);
      is_bot  = (cr == h_eff - 12'd1);
      last    = (case_a || case_b) && is_re && is_bot;
      if (last) begin
         col_in = '0;
         row_in = '0;
      end else if (ic_next >= w_eff) begin
         col_in = '0;
         row_in = row_ff + 13'd1;
      end else begin
         col_in = CW'(ic_next);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff       <= req_data.flush ? 8'd0 : req_data.pixel;
         addr_ff      <= ic;
         ml_ff        <= (cc == '0);
         mr_ff        <= is_re;
         mt_ff        <= (cr == 12'd0);
         mb_ff        <= is_bot;
         row_end_ff   <= is_re;
         frame_end_ff <= last;
      end
   end

   // line buffers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_older_ff <= older_mem[ic];
         rd_newer_ff <= newer_mem[ic];
      end
      if (cmd.load) begin
         older_mem[addr_ff] <= rd_newer_ff;
         newer_mem[addr_ff] <= pix_ff;
      end
   end

   // shifted window with border masks
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         nw[r][0] = win_ff[r][1];
         nw[r][1] = win_ff[r][2];
      end
      nw[0][2] = rd_older_ff;
      nw[1][2] = rd_newer_ff;
      nw[2][2] = pix_ff;
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            if ((k == 0 && ml_ff) || (k == 2 && mr_ff) ||
                (r == 0 && mt_ff) || (r == 2 && mb_ff)) begin
               ps[r][k] = '0;
            end else begin
               ps[r][k] = $signed({3'b000, nw[r][k]});
            end
         end
      end
      gx = (ps[0][2] + (ps[1][2] <<< 1) + ps[2][2]) - (ps[0][0] + (ps[1][0] <<< 1) + ps[2][0]);
      gy = (ps[2][0] + (ps[2][1] <<< 1) + ps[2][2]) - (ps[0][0] + (ps[0][1] <<< 1) + ps[0][2]);
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         col_ff <= '0;
         row_ff <= '0;
         has_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[r][k] <= '0;
            end
         end
      end else begin
         if (cmd.accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
            has_ff <= case_a || case_b;
         end
         if (cmd.load) begin
            win_ff <= nw;
         end
      end
   end

   // squares and root
   assign gx_sq = gx_ff * gx_ff;
   assign gy_sq = gy_ff * gy_ff;
   assign sum   = {1'b0, gx2_ff} + {1'b0, gy2_ff};
   assign t     = root_ff | (8'd1 << bit_ff);
   assign t_sq  = t * t;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         gx_ff <= gx;
         gy_ff <= gy;
      end
      if (cmd.square) begin
         gx2_ff <= gx_sq[19:0];
         gy2_ff <= gy_sq[19:0];
      end
      if (cmd.sum) begin
         rad_ff  <= (sum[20:16] != 5'd0) ? 16'hFFFF : sum[15:0];
         root_ff <= '0;
         bit_ff  <= 3'd7;
      end
      if (cmd.root_step) begin
         if (t_sq <= rad_ff) begin
            root_ff <= t;
         end
         bit_ff <= bit_ff - 3'd1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.magnitude <= root_ff;
         rsp_ff.row_end   <= row_end_ff;
         rsp_ff.frame_end <= frame_end_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_ff;
   assign sts.has_result = has_ff;
   assign sts.root_done  = (bit_ff == 3'd0);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   `SGM_ASSERT_NEXT(a_emit_shows, clock, reset, cmd.emit, rsp_valid_ff)
   `SGM_ASSERT_IMPLY(a_emit_free, clock, reset, cmd.emit, !rsp_valid_ff || rsp_ready)
   `SGM_ASSERT_IMPLY(a_col_range, clock, reset, 1'b1, WW'(col_ff) < w_eff)

endmodule

/* hdl/sobel_gradient_magnitude.sv */
// top level of the streaming sobel gradient magnitude block
`timescale 1ns / 1ps
// Takes one raster pixel per request and returns floor(sqrt(Gx^2+Gy^2)), saturated at 255,
// for each image pixel one row plus one pixel later, so width+1 flush requests follow a
// frame. A request that yields no result returns to idle after its load step; one that yields
// a result goes through the line buffer read, gradient, squaring and sum steps and the 8-step
// square root loop before the result register is loaded. A new request is taken while the
// previous result waits in the output register. Image size writes restart the frame.
module sobel_gradient_magnitude
   import sgm_pkg::*;
#(
   parameter int MAX_WIDTH = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   sgm_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sgm_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

/* sim/sgm_checker.sv */
// checker for the sobel gradient magnitude block: predicts results from observed requests and compares
`timescale 1ns / 1ps
module sgm_checker
   import sgm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   localparam int LINE_DEPTH = 512;

   logic [9:0]  cfg_width;
   logic [11:0] cfg_height;
   logic [7:0]  line_old [LINE_DEPTH];
   logic [7:0]  line_new [LINE_DEPTH];
   logic [7:0]  win [9];
   int          col_pos;
   int          row_pos;
   rsp_type     expected_q [$];

   assign pending = expected_q.size();

   function automatic int width_in_use();
      if (cfg_width == 0) return 1;
      if (cfg_width > LINE_DEPTH) return LINE_DEPTH;
      return cfg_width;
   endfunction

   function automatic int height_in_use();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   function automatic rsp_type gradient_at(int off, int cr, int cc, int w, int h);
      int p [3][3];
      int gx;
      int gy;
      int sq;
      int root;
      int trial;
      rsp_type res;
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            p[r][k] = (off + k <= 2) ? int'(win[r * 3 + off + k]) : 0;
            if ((k == 0 && cc == 0) || (k == 2 && cc == w - 1) ||
                (r == 0 && cr == 0) || (r == 2 && cr == h - 1))
               p[r][k] = 0;
         end
      end
      gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
      gy = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
      sq = gx * gx + gy * gy;
      root = 0;
      for (int b = 7; b >= 0; b--) begin
         trial = root | (1 << b);
         if (trial * trial <= sq) root = trial;
      end
      res.magnitude = (sq >= 65536) ? 8'd255 : root[7:0];
      res.row_end   = (cc == w - 1);
      res.frame_end = (cc == w - 1) && (cr == h - 1);
      return res;
   endfunction

   task automatic predict_pixel(req_type rq);
      int w;
      int h;
      int ic;
      int ir;
      logic [7:0] v;
      logic [7:0] fresh [3];
      logic last;
      rsp_type res;
      w = width_in_use();
      h = height_in_use();
      ic = (col_pos >= w) ? 0 : col_pos;
      ir = row_pos;
      v = rq.flush ? 8'd0 : rq.pixel;
      last = 1'b0;
      if (ic == 0 && ir >= 2 && ir - 2 < h) begin
         res = gradient_at(1, ir - 2, w - 1, w, h);
         expected_q.push_back(res);
         last = res.frame_end;
      end
      fresh[0] = line_old[ic];
      fresh[1] = line_new[ic];
      fresh[2] = v;
      line_old[ic] = line_new[ic];
      line_new[ic] = v;
      for (int r = 0; r < 3; r++) begin
         win[r * 3] = win[r * 3 + 1];
         win[r * 3 + 1] = win[r * 3 + 2];
         win[r * 3 + 2] = fresh[r];
      end
      if (ic >= 1 && ir >= 1 && ir - 1 < h) begin
         res = gradient_at(0, ir - 1, ic - 1, w, h);
         expected_q.push_back(res);
         last = res.frame_end;
      end
      if (last) begin
         col_pos = 0;
         row_pos = 0;
      end else begin
         ic++;
         if (ic >= w) begin
            ic = 0;
            ir++;
         end
         col_pos = ic;
         row_pos = ir;
      end
   endtask

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_width = WIDTH_RESET;
         cfg_height = HEIGHT_RESET;
         foreach (win[i]) win[i] = '0;
         col_pos = 0;
         row_pos = 0;
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report("unexpected result", rsp_data, 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.magnitude !== want.magnitude)
                  report("magnitude", rsp_data.magnitude, want.magnitude);
               if (rsp_data.row_end !== want.row_end)
                  report("row_end", rsp_data.row_end, want.row_end);
               if (rsp_data.frame_end !== want.frame_end)
                  report("frame_end", rsp_data.frame_end, want.frame_end);
            end
         end
         if (req_valid && req_ready) predict_pixel(req_data);
         if (csr_we) begin
            if (csr_index == REG_IMAGE_WIDTH) cfg_width = csr_wdata[9:0];
            else cfg_height = csr_wdata;
            foreach (win[i]) win[i] = '0;
            col_pos = 0;
            row_pos = 0;
         end
      end
   end
endmodule

/* sim/tb_sobel_gradient_magnitude.sv */
// testbench top for the sobel gradient magnitude block: stimulus, stalls and verdict
`timescale 1ns / 1ps
module tb_sobel_gradient_magnitude;
   import sgm_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic        csr_index;
   logic [11:0] csr_wdata;
   int          fail_count;
   int          pending;
   int          idle_cycles;
   bit          hold_rsp;
   bit          quiet_sink;

   sobel_gradient_magnitude u_top (.*);

   sgm_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: random stalls, or a long hold-off when asked
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = quiet_sink ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock iff rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || hold_rsp)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[sobel_gradient_magnitude] ERROR");
         $finish;
      end
   end

   // valid stays high into the next request when there is no gap
   task automatic send_request(logic [7:0] pix, logic fl, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{pixel: pix, flush: fl};
      @(posedge clock iff req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock iff pending == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [11:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // one frame: pixels from a chosen style, some sent as flush, then width+1 flush requests
   task automatic send_frame(int w, int h, int style, bit no_gap);
      logic [7:0] pix;
      for (int i = 0; i < w * h + w + 1; i++) begin
         case (style)
            0: pix = 8'($urandom_range(0, 255));
            1: pix = ((i % w) + (i / w)) % 2 ? 8'hff : 8'h00;
            2: pix = 8'hff;
            default: pix = ($urandom_range(0, 1)) ? 8'hff : 8'h00;
         endcase
         if (i >= w * h) send_request(pix, 1'b1, no_gap);
         else send_request(pix, ($urandom_range(0, 15) == 0), no_gap);
      end
   endtask

   initial begin
      int w;
      int h;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = REG_IMAGE_WIDTH;
      csr_wdata = '0;
      hold_rsp  = 1'b0;
      quiet_sink = 1'b0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single pixel frame, then zero in both registers
      write_reg(REG_IMAGE_WIDTH, 12'd1);
      write_reg(REG_IMAGE_HEIGHT, 12'd1);
      send_request(8'hff, 1'b0, 1'b0);
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'h00, 1'b1, 1'b0);
      wait_drained();
      write_reg(REG_IMAGE_WIDTH, 12'd0);
      write_reg(REG_IMAGE_HEIGHT, 12'd0);
      send_request(8'h80, 1'b0, 1'b0);
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'h00, 1'b1, 1'b0);
      wait_drained();
      // saturation with a checkerboard and an all-white frame
      write_reg(REG_IMAGE_WIDTH, 12'd4);
      write_reg(REG_IMAGE_HEIGHT, 12'd3);
      send_frame(4, 3, 1, 1'b0);
      wait_drained();
      write_reg(REG_IMAGE_WIDTH, 12'd3);
      write_reg(REG_IMAGE_HEIGHT, 12'd2);
      send_frame(3, 2, 2, 1'b0);
      wait_drained();

      // a long row once, with a long receiver hold-off, one row tall
      write_reg(REG_IMAGE_WIDTH, 12'd128);
      write_reg(REG_IMAGE_HEIGHT, 12'd1);
      hold_rsp = 1'b1;
      send_frame(128, 1, 0, 1'b1);
      wait_drained();
      // oversized width is clamped to MAX_WIDTH, non-flush items within the first row
      write_reg(REG_IMAGE_WIDTH, 12'd1023);
      write_reg(REG_IMAGE_HEIGHT, 12'd4095);
      for (int i = 0; i < 40; i++) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      wait_drained();

      // random small frames, including extra items after a frame
      repeat (4) begin
         w = $urandom_range(1, 9);
         h = $urandom_range(1, 6);
         write_reg(REG_IMAGE_WIDTH, 12'(w));
         write_reg(REG_IMAGE_HEIGHT, 12'(h));
         quiet_sink = ($urandom_range(0, 3) == 0);
         send_frame(w, h, $urandom_range(0, 3), quiet_sink);
         if ($urandom_range(0, 1)) send_frame(w, h, 0, 1'b0);
         wait_drained();
      end
      quiet_sink = 1'b0;
      wait_drained();

      if (fail_count == 0)
         $display("[sobel_gradient_magnitude] OK");
      else
         $display("[sobel_gradient_magnitude] ERROR");
      $finish;
   end
endmodule

/* files.f */
+incdir+hdl
hdl/sgm_pkg.sv
hdl/sgm_control.sv
hdl/sgm_datapath.sv
hdl/sobel_gradient_magnitude.sv
sim/sgm_checker.sv
sim/tb_sobel_gradient_magnitude.sv
